[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define VIDD_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check an implication; cons may open with a ## delay.
`define VIDD_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error(msg);

`endif

[rtl/vidd_pkg.sv]
package vidd_pkg;

	localparam int MAX_VERTICES = 1024;

	// entries held by one cell of the match chain
	localparam int SLOTS = 8;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int NUM_CELLS = (MAX_VERTICES + SLOTS - 1) / SLOTS;
	localparam int CELL_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
	localparam int ADDR_W = CELL_W + SLOT_W;
	localparam int WIDE_W = ADDR_W + 1;
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);

	localparam int FIELD_W = 16;
	localparam int VIDX_W = 10;
	localparam int UCNT_W = 11;

	typedef struct packed {
		logic [FIELD_W-1:0] pos;
		logic [FIELD_W-1:0] tex;
		logic [FIELD_W-1:0] nrm;
	} key_t;

	typedef struct packed {
		logic              valid;
		key_t              key;
		logic              found;
		logic [ADDR_W-1:0] vid;
	} tok_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		key_t              key;
	} wr_t;

	typedef struct packed {
		logic [VIDX_W-1:0]  vertex_index;
		logic               is_new;
		logic               overflow;
		logic [FIELD_W-1:0] pos_out;
		logic [FIELD_W-1:0] tex_out;
		logic [FIELD_W-1:0] nrm_out;
		logic [FIELD_W-1:0] joint_out;
		logic [FIELD_W-1:0] weight_out;
		logic [UCNT_W-1:0]  unique_count;
		logic [FIELD_W-1:0] corner_count;
	} res_t;

	typedef enum logic {
		ST_IDLE,
		ST_SEARCH
	} state_t;

endpackage

[rtl/vidd_cell.sv]
module vidd_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [vidd_pkg::CELL_W-1:0] cell_id,
	input  logic [vidd_pkg::CNT_W-1:0]  count,
	input  vidd_pkg::wr_t               wr,
	input  vidd_pkg::tok_t              tok_in,
	output vidd_pkg::tok_t              tok_out
);

	vidd_pkg::key_t                slot_q [vidd_pkg::SLOTS];
	logic [vidd_pkg::ADDR_W-1:0]   idx [vidd_pkg::SLOTS];
	logic [vidd_pkg::SLOTS-1:0]    hit;
	vidd_pkg::tok_t                tok_q;
	vidd_pkg::tok_t                tok_nxt;

	for (genvar g = 0; g < vidd_pkg::SLOTS; g++) begin : g_slot
		assign idx[g] = {cell_id, vidd_pkg::SLOT_W'(g)};
		// only entries below the fill count hold live triples
		assign hit[g] = (vidd_pkg::WIDE_W'(idx[g]) < vidd_pkg::WIDE_W'(count))
			&& (slot_q[g] == tok_in.key);

		always_ff @(posedge clk) begin
			if (wr.en && (wr.addr == idx[g])) begin
				slot_q[g] <= wr.key;
			end
		end
	end

	always_comb begin
		tok_nxt = tok_in;
		if (tok_in.valid && !tok_in.found) begin
			// walk downward so the lowest matching slot wins
			for (int j = vidd_pkg::SLOTS - 1; j >= 0; j--) begin
				if (hit[j]) begin
					tok_nxt.found = 1'b1;
					tok_nxt.vid = idx[j];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_out = tok_q;

endmodule

[rtl/vertex_index_dedup.sv]
// channel   direction  handshake            payload
// cfg       in         cfg_wr_en            cfg_wr_data (rig_mode)
// corner    in         in_valid/in_stall    start_mesh, pos/tex/nrm/joint/weight_index
// vertex    out        out_valid/out_stall  vertex_index ... corner_count
//
// A corner word walks the chain of NUM_CELLS match cells, one cell per cycle
// (128 cells at 1024 vertices); one corner is in the chain at a time, and the
// next corner is accepted only once the word has left the chain and, with the
// output free, its pending result has been handed on to the result register.
// Reset clears counters and the chain; stored triples stay undefined and are
// masked by the fill count, so no clearing pass runs.
// A result register and one pending stage let the next corner enter while a
// result is held by out_stall.
`include "assert_macros.svh"

module vertex_index_dedup (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic                            cfg_wr_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            start_mesh,
	input  logic [vidd_pkg::FIELD_W-1:0]    pos_index,
	input  logic [vidd_pkg::FIELD_W-1:0]    tex_index,
	input  logic [vidd_pkg::FIELD_W-1:0]    nrm_index,
	input  logic [vidd_pkg::FIELD_W-1:0]    joint_index,
	input  logic [vidd_pkg::FIELD_W-1:0]    weight_index,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [vidd_pkg::VIDX_W-1:0]     vertex_index,
	output logic                            is_new,
	output logic                            overflow,
	output logic [vidd_pkg::FIELD_W-1:0]    pos_out,
	output logic [vidd_pkg::FIELD_W-1:0]    tex_out,
	output logic [vidd_pkg::FIELD_W-1:0]    nrm_out,
	output logic [vidd_pkg::FIELD_W-1:0]    joint_out,
	output logic [vidd_pkg::FIELD_W-1:0]    weight_out,
	output logic [vidd_pkg::UCNT_W-1:0]     unique_count,
	output logic [vidd_pkg::FIELD_W-1:0]    corner_count
);

	vidd_pkg::state_t               state_q;
	vidd_pkg::state_t               state_d;
	logic                           rig_q;
	logic [vidd_pkg::CNT_W-1:0]     count_q;
	logic [vidd_pkg::CNT_W-1:0]     count_in;
	logic [vidd_pkg::FIELD_W-1:0]   corners_q;
	logic [vidd_pkg::FIELD_W-1:0]   joint_q;
	logic [vidd_pkg::FIELD_W-1:0]   weight_q;
	logic                           pend_q;
	vidd_pkg::res_t                 pend_res_q;
	logic                           out_vld_q;
	vidd_pkg::res_t                 out_res_q;

	vidd_pkg::tok_t                 chain [vidd_pkg::NUM_CELLS + 1];
	vidd_pkg::tok_t                 tail_tok;
	vidd_pkg::wr_t                  wr;
	vidd_pkg::res_t                 res;
	logic                           accept;
	logic                           room;
	logic                           insert;
	logic [vidd_pkg::ADDR_W-1:0]    vid_sel;
	logic [31:0]                    vid_ext;
	logic [31:0]                    cnt_ext;
	logic                           move;

	assign accept = in_valid && !in_stall;
	assign tail_tok = chain[vidd_pkg::NUM_CELLS];

	always_comb begin
		state_d = state_q;
		in_stall = 1'b1;
		chain[0] = '0;
		case (state_q)
			vidd_pkg::ST_IDLE: begin
				in_stall = pend_q;
				if (in_valid && !pend_q) begin
					chain[0].valid = 1'b1;
					chain[0].key = '{pos: pos_index, tex: tex_index, nrm: nrm_index};
					state_d = vidd_pkg::ST_SEARCH;
				end
			end
			vidd_pkg::ST_SEARCH: begin
				if (tail_tok.valid) begin
					state_d = vidd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = vidd_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vidd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// a starting corner must not match the old mesh in the first cell
	assign count_in = (accept && start_mesh) ? '0 : count_q;

	for (genvar c = 0; c < vidd_pkg::NUM_CELLS; c++) begin : g_cell
		vidd_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cell_id (vidd_pkg::CELL_W'(c)),
			.count   (count_in),
			.wr      (wr),
			.tok_in  (chain[c]),
			.tok_out (chain[c + 1])
		);
	end

	// append at the fill count when the word leaves the chain unmatched and the table is not full
	assign room = vidd_pkg::WIDE_W'(count_q) < vidd_pkg::WIDE_W'(vidd_pkg::MAX_VERTICES);
	assign insert = tail_tok.valid && !tail_tok.found && room;
	assign wr = '{en: insert, addr: vidd_pkg::ADDR_W'(count_q), key: tail_tok.key};

	always_comb begin
		if (tail_tok.found) begin
			vid_sel = tail_tok.vid;
		end else if (room) begin
			vid_sel = vidd_pkg::ADDR_W'(count_q);
		end else begin
			vid_sel = '0;
		end
		vid_ext = 32'(vid_sel);
		cnt_ext = 32'(count_q) + 32'(insert);
		res.vertex_index = vid_ext[vidd_pkg::VIDX_W-1:0];
		res.is_new = insert;
		res.overflow = !tail_tok.found && !room;
		res.pos_out = insert ? tail_tok.key.pos : '0;
		res.tex_out = insert ? tail_tok.key.tex : '0;
		res.nrm_out = insert ? tail_tok.key.nrm : '0;
		res.joint_out = (insert && rig_q) ? joint_q : '0;
		res.weight_out = (insert && rig_q) ? weight_q : '0;
		res.unique_count = cnt_ext[vidd_pkg::UCNT_W-1:0];
		res.corner_count = corners_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rig_q <= 1'b0;
			count_q <= '0;
			corners_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				rig_q <= cfg_wr_data;
			end
			if (accept) begin
				if (start_mesh) begin
					count_q <= '0;
					corners_q <= vidd_pkg::FIELD_W'(1);
				end else if (corners_q != '1) begin
					corners_q <= corners_q + vidd_pkg::FIELD_W'(1);
				end
			end else if (insert) begin
				count_q <= count_q + vidd_pkg::CNT_W'(1);
			end
		end
	end

	// hold the side fields of the corner in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			joint_q <= joint_index;
			weight_q <= weight_index;
		end
	end

	assign move = pend_q && (!out_vld_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (tail_tok.valid) begin
				pend_q <= 1'b1;
			end else if (move) begin
				pend_q <= 1'b0;
			end
			if (move) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tail_tok.valid) begin
			pend_res_q <= res;
		end
		if (move) begin
			out_res_q <= pend_res_q;
		end
	end

	assign out_valid = out_vld_q;
	assign vertex_index = out_res_q.vertex_index;
	assign is_new = out_res_q.is_new;
	assign overflow = out_res_q.overflow;
	assign pos_out = out_res_q.pos_out;
	assign tex_out = out_res_q.tex_out;
	assign nrm_out = out_res_q.nrm_out;
	assign joint_out = out_res_q.joint_out;
	assign weight_out = out_res_q.weight_out;
	assign unique_count = out_res_q.unique_count;
	assign corner_count = out_res_q.corner_count;

	`VIDD_ASSERT_ALWAYS(a_count_max,
		vidd_pkg::WIDE_W'(count_q) <= vidd_pkg::WIDE_W'(vidd_pkg::MAX_VERTICES),
		"fill count beyond table size")
	`VIDD_ASSERT_IMPL(a_chain_latency, accept, ##(vidd_pkg::NUM_CELLS) tail_tok.valid,
		"corner word did not leave the chain on time")
	`VIDD_ASSERT_IMPL(a_idle_empty, state_q == vidd_pkg::ST_IDLE, !tail_tok.valid,
		"corner word left the chain while idle")
	`VIDD_ASSERT_IMPL(a_new_no_ovf, out_valid, !(is_new && overflow),
		"result both new and overflowed")

endmodule
